/* design/rss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// shared constants for the rotated sorted array search core
// ----------------------------------------------------------------------------
package rss_pkg;

  // element and target width
  localparam int DATA_W = 32;

  // default element store depth
  localparam int MAX_ELEMENTS_DEF = 64;

endpackage
`default_nettype wire

/* design/rotated_sorted_search_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_sorted_search_core
// membership search on a rotated non-decreasing array with duplicates
// ----------------------------------------------------------------------------
// A load beat (mode 0) appends one signed element to an internal store of
// MAX_ELEMENTS entries; restart on a load empties the store and clears the
// overflow flag first, and loads into a full store are dropped and set the
// flag. A search beat (mode 1) returns one result beat holding found and the
// overflow flag. The search is a modified binary search run by a small
// sequencer around an element memory with its own write port and a registered
// read: each iteration reads the low, mid and high elements one after another
// and then evaluates them. A search ends on a hit or on an empty range, and
// its result may then wait on out_stall. It takes about log2(n) iterations on
// distinct data, up to about n/2 when duplicates force both ends inward one
// step at a time. in_stall is high from the cycle after a search beat until
// its result is loaded into the output register; loads and searches are taken
// while an earlier result still waits on out_stall.
// ----------------------------------------------------------------------------
module rotated_sorted_search_core #(
  parameter int MAX_ELEMENTS = rss_pkg::MAX_ELEMENTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // input channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_mode,
  input  wire signed [rss_pkg::DATA_W-1:0] in_value,
  input  wire                             in_restart,
  // result channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_found,
  output logic                            out_overflowed
);

  // address width of the element memory
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  // count width, wide enough to hold MAX_ELEMENTS itself
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  // signed search index, one extra bit so hi can reach -1
  localparam int IDX_W  = CNT_W + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;  // range test, read lo
  localparam logic [2:0] S_RD_MID = 3'd2;  // capture lo value, read mid
  localparam logic [2:0] S_RD_HI  = 3'd3;  // capture mid value, read hi
  localparam logic [2:0] S_EVAL   = 3'd4;  // compare and narrow the range
  localparam logic [2:0] S_FINISH = 3'd5;  // hand result to output register

  // element memory
  logic signed [rss_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [rss_pkg::DATA_W-1:0] rdata_r;
  logic [ADDR_W-1:0]                 rd_addr;
  logic                              wr_en;
  logic [ADDR_W-1:0]                 wr_addr;

  // control and search state
  logic [2:0]                        state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              ovf_r, ovf_nxt;
  logic signed [IDX_W-1:0]           lo_r, lo_nxt;
  logic signed [IDX_W-1:0]           hi_r, hi_nxt;
  logic signed [IDX_W-1:0]           mid_r;
  logic signed [IDX_W-1:0]           mid_calc;
  logic signed [IDX_W-1:0]           span;
  logic signed [rss_pkg::DATA_W-1:0] tgt_r;
  logic signed [rss_pkg::DATA_W-1:0] vl_r;
  logic signed [rss_pkg::DATA_W-1:0] vm_r;
  logic                              hit_r, hit_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_found_r;
  logic                              out_ovf_r;
  logic                              out_load;

  logic                              in_fire;
  logic                              room;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign room     = (cnt_r < CNT_W'(MAX_ELEMENTS));

  // midpoint, span is never negative when used
  assign span     = hi_r - lo_r;
  assign mid_calc = lo_r + (span >>> 1);

  // load writes: a restart load always lands at entry zero
  assign wr_en   = in_fire && !in_mode && (in_restart || room);
  assign wr_addr = in_restart ? '0 : cnt_r[ADDR_W-1:0];

  // read address follows the sequencer
  always_comb begin
    case (state_r)
      S_CHECK:  rd_addr = lo_r[ADDR_W-1:0];
      S_RD_MID: rd_addr = mid_r[ADDR_W-1:0];
      S_RD_HI:  rd_addr = hi_r[ADDR_W-1:0];
      default:  rd_addr = lo_r[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    rdata_r <= mem[rd_addr];
  end

  // sequencer and shared compare step
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    hit_nxt       = hit_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_mode) begin
            if (in_restart) begin
              cnt_nxt = CNT_W'(1);
              ovf_nxt = 1'b0;
            end else if (room) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            lo_nxt    = '0;
            hi_nxt    = $signed({1'b0, cnt_r}) - IDX_W'(1);
            hit_nxt   = 1'b0;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // empty range ends the search as a miss
        if (lo_r <= hi_r) begin
          state_nxt = S_RD_MID;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_RD_MID: state_nxt = S_RD_HI;
      S_RD_HI:  state_nxt = S_EVAL;
      S_EVAL: begin
        if (vm_r == tgt_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CHECK;
          if (vl_r == vm_r && vm_r == rdata_r) begin
            // all three equal, pull both ends in
            lo_nxt = lo_r + IDX_W'(1);
            hi_nxt = hi_r - IDX_W'(1);
          end else if (vl_r <= vm_r) begin
            // left half sorted
            if (vl_r <= tgt_r && tgt_r <= vm_r) begin
              hi_nxt = mid_r - IDX_W'(1);
            end else begin
              lo_nxt = mid_r + IDX_W'(1);
            end
          end else begin
            // right half sorted
            if (vm_r <= tgt_r && tgt_r <= rdata_r) begin
              lo_nxt = mid_r + IDX_W'(1);
            end else begin
              hi_nxt = mid_r - IDX_W'(1);
            end
          end
        end
      end
      S_FINISH: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    hit_r <= hit_nxt;
    if (in_fire && in_mode) begin
      tgt_r <= in_value;
    end
    if (state_r == S_CHECK) begin
      mid_r <= mid_calc;
    end
    if (state_r == S_RD_MID) begin
      vl_r <= rdata_r;
    end
    if (state_r == S_RD_HI) begin
      vm_r <= rdata_r;
    end
    if (out_load) begin
      out_found_r <= hit_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_overflowed = out_ovf_r;

endmodule
`default_nettype wire

/* design/rss_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rss_checker
// port-level checks for the rotated sorted array search core
// ----------------------------------------------------------------------------
module rss_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_stall,
  input wire in_mode,
  input wire out_valid,
  input wire out_stall,
  input wire out_found,
  input wire out_overflowed
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) && $stable(out_overflowed))
    else $error("result beat changed while stalled");

  // a search keeps the input side busy
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> in_stall)
    else $error("input not stalled after search beat");

  // a load leaves the input side free
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode |=> !in_stall)
    else $error("input stalled after load beat");

  // a result only appears at the end of a search
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a search in progress");

endmodule

bind rotated_sorted_search_core rss_checker u_rss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_found      (out_found),
  .out_overflowed (out_overflowed)
);
`default_nettype wire
